// ----- rtl/json_string_unescape_defines.svh -----
// assertion macros used by rtl/json_string_unescape.sv
// both sample on clk and are off while rst is high
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the following cycle
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/jsu_pkg.sv -----
`default_nettype none

package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_HEX,
    MODE_ERR
  } mode_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_HEX  = 2'd1;
  localparam logic [1:0] ST_OPEN_ESC = 2'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic [1:0] status;
    logic       run_last;
  } out_t;

  // decoder state: three hex digits at most are held before the fourth completes
  typedef struct packed {
    mode_t       mode;
    logic [1:0]  digits;
    logic [11:0] cp;
    logic [1:0]  err;
  } st_t;

  // results of one request, bytes[0] goes out first
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic            has_bytes;
    logic            fin;
    logic [1:0]      status;
  } dec_t;

endpackage

`default_nettype wire

// ----- rtl/json_string_unescape.sv -----
`default_nettype none
// channel  struct  handshake              direction
// src      in_t    src_valid / src_stall  raw string bytes in
// dst      out_t   dst_valid / dst_stall  decoded bytes out
//
// one request is decoded in the cycle it is taken; its 0 to 3 results
// sit in a small result buffer and leave one per cycle unless dst stalls
// plain bytes, short escapes: one request per cycle unless dst stalls; a
// \u escape of 2 or 3 utf-8 bytes holds src until one result is left
// src_stall follows dst_stall while the last buffered result is waiting
// rst is synchronous: text mode, no error, result buffer empty

module json_string_unescape (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  output logic          src_stall,
  input  jsu_pkg::in_t  src_item,
  output logic          dst_valid,
  input  logic          dst_stall,
  output jsu_pkg::out_t dst_item
);
  import jsu_pkg::*;

  st_t             state;
  st_t             state_step;
  st_t             state_next;
  dec_t            dec;
  logic [1:0]      cnt;
  logic [2:0][7:0] bytes;
  logic            has_bytes;
  logic            fin;
  logic [1:0]      status;
  logic            src_acc;
  logic            dst_acc;
  logic            last;

  jsu_decode u_decode (
    .cur  (state),
    .item (src_item),
    .step (state_step),
    .res  (dec)
  );

  // the final byte of a string returns the decoder to its reset state
  always_comb begin
    state_next = state_step;
    if (src_item.final_byte) begin
      state_next.mode   = MODE_TEXT;
      state_next.digits = 2'd0;
      state_next.cp     = '0;
      state_next.err    = ST_OK;
    end
  end

  assign dst_acc   = dst_valid && !dst_stall;
  assign src_stall = !(cnt == 2'd0 || (cnt == 2'd1 && !dst_stall));
  assign src_acc   = src_valid && !src_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode   <= MODE_TEXT;
      state.digits <= 2'd0;
      state.cp     <= '0;
      state.err    <= ST_OK;
    end else if (src_acc) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (src_acc) begin
      cnt <= dec.count;
    end else if (dst_acc) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (src_acc) begin
      bytes     <= dec.bytes;
      has_bytes <= dec.has_bytes;
      fin       <= dec.fin;
      status    <= dec.status;
    end else if (dst_acc) begin
      bytes <= {8'h00, bytes[2:1]};
    end
  end

  assign last                = (cnt == 2'd1);
  assign dst_valid           = (cnt != 2'd0);
  assign dst_item.out_byte   = bytes[0];
  assign dst_item.byte_valid = has_bytes;
  assign dst_item.string_end = fin && last;
  assign dst_item.status     = (fin && last) ? status : ST_OK;
  assign dst_item.run_last   = last;

`include "json_string_unescape_defines.svh"

  `JSU_ASSERT_NOW(a_end_is_last, dst_valid && dst_item.string_end, dst_item.run_last, "string end not on last result")
  `JSU_ASSERT_NOW(a_status_at_end, dst_valid && dst_item.status != ST_OK, dst_item.string_end, "status off the string end")
  `JSU_ASSERT_NEXT(a_fin_clears, src_acc && src_item.final_byte, state.mode == MODE_TEXT && state.err == ST_OK, "decoder not cleared after final byte")
  `JSU_ASSERT_NOW(a_err_mode, state.mode == MODE_ERR, state.err == ST_BAD_HEX, "error mode without bad hex status")
  `JSU_ASSERT_NEXT(a_pending_kept, dst_valid && !dst_item.run_last, dst_valid, "pending results dropped")

endmodule

`default_nettype wire

// ----- rtl/jsu_decode.sv -----
`default_nettype none

module jsu_decode (
  input  jsu_pkg::st_t cur,
  input  jsu_pkg::in_t item,
  output jsu_pkg::st_t step,
  output jsu_pkg::dec_t res
);
  import jsu_pkg::*;

  logic [7:0]  b;
  logic        fin;
  logic        hex_ok;
  logic [3:0]  nib;
  logic [15:0] cpf;
  logic [7:0]  esc;
  logic [1:0]  n;

  assign b   = item.in_byte;
  assign fin = item.final_byte;

  always_comb begin
    hex_ok = 1'b1;
    nib    = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      nib = b[3:0];
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      nib = b[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    case (b)
      8'h6e:   esc = 8'h0a;
      8'h74:   esc = 8'h09;
      8'h72:   esc = 8'h0d;
      8'h62:   esc = 8'h08;
      8'h66:   esc = 8'h0c;
      default: esc = b;
    endcase
  end

  assign cpf = {cur.cp, nib};

  // next state before the end-of-string clear
  always_comb begin
    step = cur;
    case (cur.mode)
      MODE_TEXT: begin
        if (b == CH_BSLASH && !fin) step.mode = MODE_ESC;
      end
      MODE_ESC: begin
        if (b == CH_U) begin
          step.mode   = MODE_HEX;
          step.digits = 2'd0;
          step.cp     = '0;
          if (fin) step.err = ST_OPEN_ESC;
        end else begin
          step.mode = MODE_TEXT;
        end
      end
      MODE_HEX: begin
        if (fin && cur.digits != 2'd3) begin
          step.err = ST_OPEN_ESC;
        end else if (!hex_ok) begin
          step.err  = ST_BAD_HEX;
          step.mode = MODE_ERR;
        end else if (cur.digits == 2'd3) begin
          step.mode   = MODE_TEXT;
          step.digits = 2'd0;
          step.cp     = '0;
        end else begin
          step.digits = cur.digits + 2'd1;
          step.cp     = cpf[11:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    n         = 2'd0;
    res.bytes = '0;
    case (cur.mode)
      MODE_TEXT: begin
        if (!(b == CH_BSLASH && !fin)) begin
          n            = 2'd1;
          res.bytes[0] = b;
        end
      end
      MODE_ESC: begin
        if (b != CH_U) begin
          n            = 2'd1;
          res.bytes[0] = esc;
        end
      end
      MODE_HEX: begin
        if (!(fin && cur.digits != 2'd3) && hex_ok && cur.digits == 2'd3) begin
          // utf-8 expansion of the finished code point
          if (cpf[15:7] == '0) begin
            n            = 2'd1;
            res.bytes[0] = {1'b0, cpf[6:0]};
          end else if (cpf[15:11] == '0) begin
            n            = 2'd2;
            res.bytes[0] = {3'b110, cpf[10:6]};
            res.bytes[1] = {2'b10, cpf[5:0]};
          end else begin
            n            = 2'd3;
            res.bytes[0] = {4'b1110, cpf[15:12]};
            res.bytes[1] = {2'b10, cpf[11:6]};
            res.bytes[2] = {2'b10, cpf[5:0]};
          end
        end
      end
      default: ;
    endcase
    res.has_bytes = (n != 2'd0);
    res.count     = (fin && n == 2'd0) ? 2'd1 : n;
    res.fin       = fin;
    res.status    = step.err;
  end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top;
  import jsu_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 31;

  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_FF  = 8'h0c;

  localparam logic [7:0]  UTF8_LEAD2  = 8'hc0;
  localparam logic [7:0]  UTF8_LEAD3  = 8'he0;
  localparam logic [7:0]  UTF8_CONT   = 8'h80;
  localparam logic [7:0]  UTF8_LOW6   = 8'h3f;
  localparam logic [15:0] UTF8_2B_MIN = 16'h0080;
  localparam logic [15:0] UTF8_3B_MIN = 16'h0800;

  localparam logic [7:0] ESC_CHARS [8] = '{"n", "t", "r", "b", "f", "\"", "\\", "/"};

  logic clk = 1'b0;
  logic rst;
  logic src_valid;
  logic src_stall;
  in_t  src_item;
  logic dst_valid;
  logic dst_stall;
  out_t dst_item;

  json_string_unescape DUT (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_item (src_item),
    .dst_valid(dst_valid),
    .dst_stall(dst_stall),
    .dst_item (dst_item)
  );

  always #4 clk = ~clk;

  // decoder state as the block should hold it
  mode_t       dec_mode = MODE_TEXT;
  logic [2:0]  hex_seen = '0;
  logic [15:0] cp_acc   = '0;
  logic [1:0]  str_err  = ST_OK;

  out_t        pending_out[$];
  logic [7:0]  str_buf[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          sent_count = 0;
  bit          idle_on = 1'b1;
  bit          hold_go = 1'b0;

  function automatic int hex_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] expand_escape(input logic [7:0] c);
    case (c)
      "n": return CH_LF;
      "t": return CH_TAB;
      "r": return CH_CR;
      "b": return CH_BS;
      "f": return CH_FF;
      default: return c;
    endcase
  endfunction

  // works out the results of one request and queues them
  task automatic decode_request(input in_t req);
    logic [7:0] bytes [3];
    logic [7:0] b;
    logic       fin;
    int         n;
    int         nib;
    int         total;
    out_t       r;
    b = req.in_byte;
    fin = req.final_byte;
    n = 0;
    case (dec_mode)
      MODE_TEXT: begin
        if (b == CH_BSLASH && !fin) begin
          dec_mode = MODE_ESC;
        end else begin
          bytes[n] = b;
          n++;
        end
      end
      MODE_ESC: begin
        if (b == CH_U) begin
          dec_mode = MODE_HEX;
          hex_seen = '0;
          cp_acc = '0;
          if (fin) str_err = ST_OPEN_ESC;
        end else begin
          bytes[n] = expand_escape(b);
          n++;
          dec_mode = MODE_TEXT;
        end
      end
      MODE_HEX: begin
        nib = hex_value(b);
        if (fin && hex_seen < 3) begin
          str_err = ST_OPEN_ESC;
        end else if (nib < 0) begin
          str_err = ST_BAD_HEX;
          dec_mode = MODE_ERR;
        end else begin
          cp_acc = {cp_acc[11:0], 4'(nib)};
          hex_seen = hex_seen + 3'd1;
          if (hex_seen >= 4) begin
            if (cp_acc < UTF8_2B_MIN) begin
              bytes[0] = cp_acc[7:0];
              n = 1;
            end else if (cp_acc < UTF8_3B_MIN) begin
              bytes[0] = UTF8_LEAD2 | {3'b000, cp_acc[10:6]};
              bytes[1] = UTF8_CONT | (cp_acc[7:0] & UTF8_LOW6);
              n = 2;
            end else begin
              bytes[0] = UTF8_LEAD3 | {4'b0000, cp_acc[15:12]};
              bytes[1] = UTF8_CONT | ({2'b00, cp_acc[11:6]} & UTF8_LOW6);
              bytes[2] = UTF8_CONT | (cp_acc[7:0] & UTF8_LOW6);
              n = 3;
            end
            dec_mode = MODE_TEXT;
            hex_seen = '0;
            cp_acc = '0;
          end
        end
      end
      default: ;
    endcase

    total = (fin && n == 0) ? 1 : n;
    for (int k = 0; k < total; k++) begin
      r.out_byte   = (n == 0) ? 8'h00 : bytes[k];
      r.byte_valid = (n != 0);
      r.string_end = fin && (k == total - 1);
      r.status     = (fin && k == total - 1) ? str_err : ST_OK;
      r.run_last   = (k == total - 1);
      pending_out.push_back(r);
    end
    if (fin) begin
      dec_mode = MODE_TEXT;
      hex_seen = '0;
      cp_acc = '0;
      str_err = ST_OK;
    end
  endtask

  // request and result monitor, scoreboard and watchdog
  always @(posedge clk) begin
    logic moved;
    out_t want;
    moved = 1'b0;
    if (!rst) begin
      if (src_valid && !src_stall) begin
        decode_request(src_item);
        moved = 1'b1;
      end
      if (dst_valid && !dst_stall) begin
        moved = 1'b1;
        if (pending_out.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: byte %h valid %b end %b status %0d last %b",
                     dst_item.out_byte, dst_item.byte_valid, dst_item.string_end,
                     dst_item.status, dst_item.run_last);
        end else begin
          want = pending_out.pop_front();
          if (dst_item.out_byte !== want.out_byte || dst_item.byte_valid !== want.byte_valid ||
              dst_item.string_end !== want.string_end || dst_item.status !== want.status ||
              dst_item.run_last !== want.run_last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: exp byte %h valid %b end %b status %0d last %b, got byte %h valid %b end %b status %0d last %b",
                       want.out_byte, want.byte_valid, want.string_end, want.status,
                       want.run_last, dst_item.out_byte, dst_item.byte_valid,
                       dst_item.string_end, dst_item.status, dst_item.run_last);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // output side: random stalls, plus one long hold on request
  initial begin
    int hold_left = 0;
    dst_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        dst_stall <= 1'b1;
      end else begin
        dst_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_t req;
    req.in_byte = b;
    req.final_byte = fin;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item <= req;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_buf.size(); i++)
      send_byte(str_buf[i], i == str_buf.size() - 1);
    str_buf.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 10) return 8'("0" + nib);
    return 8'((upper ? "A" : "a") + nib - 10);
  endfunction

  task automatic push_unicode(input logic [15:0] cp, input int ndig);
    str_buf.push_back(CH_BSLASH);
    str_buf.push_back(CH_U);
    for (int i = 0; i < ndig; i++)
      str_buf.push_back(hex_char(cp[15 - 4*i -: 4], $urandom_range(1)));
  endtask

  function automatic logic [15:0] random_code_point();
    case ($urandom_range(2))
      0: return 16'($urandom_range(16'h007f));
      1: return 16'($urandom_range(16'h07ff, 16'h0080));
      default: return 16'($urandom_range(16'hffff, 16'h0800));
    endcase
  endfunction

  task automatic push_token();
    logic [7:0] b;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        do b = 8'($urandom_range(255)); while (b == CH_BSLASH);
        str_buf.push_back(b);
      end
      5, 6: begin
        str_buf.push_back(CH_BSLASH);
        if ($urandom_range(8) == 8) begin
          do b = 8'($urandom_range(255)); while (b == CH_U);
          str_buf.push_back(b);
        end else begin
          str_buf.push_back(ESC_CHARS[$urandom_range(7)]);
        end
      end
      default: push_unicode(random_code_point(), 4);
    endcase
  endtask

  // a well-formed string, or one broken in a unicode escape or by a trailing backslash
  task automatic send_random_string(input bit broken);
    logic [7:0] b;
    int ntok;
    ntok = $urandom_range(6, 1);
    for (int i = 0; i < ntok; i++) push_token();
    if (broken) begin
      case ($urandom_range(2))
        0: begin
          push_unicode(random_code_point(), $urandom_range(3));
          do b = 8'($urandom_range(255)); while (hex_value(b) >= 0);
          str_buf.push_back(b);
          repeat ($urandom_range(2)) push_token();
        end
        1: push_unicode(random_code_point(), $urandom_range(3));
        default: str_buf.push_back(CH_BSLASH);
      endcase
    end
    send_string();
  endtask

  task automatic send_noise();
    repeat ($urandom_range(6, 1))
      send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic test_directed_cases();
    str_buf = '{8'h00, 8'hff};
    send_string();
    push_text("\\");
    send_string();
    push_text("\\u07ff");
    send_string();
    push_text("\\uFfFF");
    send_string();
    // bad digit, rest of the string is dropped, end comes alone
    push_text("\\u1Ga");
    send_string();
    push_text("\\u12");
    send_string();
    push_text("\\u123Z");
    send_string();
  endtask

  task automatic test_output_hold();
    idle_on = 1'b0;
    hold_go = 1'b1;
    push_text("\\uFFFF\\u0800\\uabcd\\u07ffxyz");
    send_string();
    idle_on = 1'b1;
  endtask

  task automatic test_full_rate(input int n_req);
    int start;
    start = sent_count;
    idle_on = 1'b0;
    while (sent_count - start < n_req) send_random_string(1'b0);
    idle_on = 1'b1;
  endtask

  task automatic test_random_strings(input int n_req);
    int start;
    int pick;
    start = sent_count;
    while (sent_count - start < n_req) begin
      pick = $urandom_range(99);
      if (pick < 80) send_random_string(1'b0);
      else if (pick < 92) send_random_string(1'b1);
      else send_noise();
    end
  endtask

  initial begin
    rst <= 1'b1;
    src_valid <= 1'b0;
    src_item <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_output_hold();
    test_full_rate(40);
    test_random_strings(135);

    src_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_out.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
